>>> rtl/vdi_pkg.sv
// Shared widths, defaults and the transaction type that travels down the cell chain.
`default_nettype none

package vdi_pkg;

  localparam int unsigned MaxDistinctDefault = 1024;
  localparam int unsigned WordW = 32;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned KeyW = WordW * KeyWords;
  localparam int unsigned IdxW = 10;

  typedef struct packed {
    logic            valid;
    logic            clr;
    logic            done;
    logic            is_new;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } vdi_item_t;

endpackage

`default_nettype wire

>>> rtl/vdi_in_if.sv
// Input channel carrying one vertex per transaction.
`default_nettype none

interface vdi_in_if;

  logic                      valid;
  logic                      ready;
  logic                      mesh_start;
  logic [vdi_pkg::WordW-1:0] pos_x;
  logic [vdi_pkg::WordW-1:0] pos_y;
  logic [vdi_pkg::WordW-1:0] pos_z;
  logic [vdi_pkg::WordW-1:0] tex_u;
  logic [vdi_pkg::WordW-1:0] tex_v;
  logic [vdi_pkg::WordW-1:0] norm_x;
  logic [vdi_pkg::WordW-1:0] norm_y;
  logic [vdi_pkg::WordW-1:0] norm_z;

  modport source (
    output valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
    input  ready
  );

  modport sink (
    input  valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/vdi_out_if.sv
// Output channel carrying one index result per transaction.
`default_nettype none

interface vdi_out_if;

  logic                     valid;
  logic                     ready;
  logic [vdi_pkg::IdxW-1:0] vertex_index;
  logic                     is_new;
  logic                     dropped;

  modport source (
    output valid, vertex_index, is_new, dropped,
    input  ready
  );

  modport sink (
    input  valid, vertex_index, is_new, dropped,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/vertex_dedup_indexer.sv
// Top level of the vertex deduplicator: a chain of table cells between two channels.
//
//   channel  modport  payload                                         role
//   vtx_i    sink     mesh_start, pos_x..z, tex_u, tex_v, norm_x..z   one vertex
//   idx_o    source   vertex_index, is_new, dropped                   one result
//
// A vertex can be accepted every cycle unless a result is held back; it moves down the chain
// one cell per cycle while the chain advances, and its result shows on idx_o after the last cell.
// Cell i holds the vertex with index i, since cells fill in order of first appearance.
// Reset clears the cell valid flags at once; there is no clearing pass.
// A stalled result stalls the whole chain, and vtx_i.ready drops with it.
`default_nettype none

module vertex_dedup_indexer #(
  parameter int unsigned MAX_DISTINCT = vdi_pkg::MaxDistinctDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vdi_in_if.sink    vtx_i,
  vdi_out_if.source idx_o
);

  vdi_pkg::vdi_item_t chain [MAX_DISTINCT+1];
  vdi_pkg::vdi_item_t last;
  logic               adv;

  assign adv         = ~idx_o.valid | idx_o.ready;
  assign vtx_i.ready = adv;

  always_comb begin
    chain[0].valid  = vtx_i.valid;
    chain[0].clr    = vtx_i.mesh_start;
    chain[0].done   = 1'b0;
    chain[0].is_new = 1'b0;
    chain[0].idx    = '0;
    chain[0].key    = {vtx_i.norm_z, vtx_i.norm_y, vtx_i.norm_x, vtx_i.tex_v,
                       vtx_i.tex_u, vtx_i.pos_z, vtx_i.pos_y, vtx_i.pos_x};
  end

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    localparam int unsigned Pos = i;
    localparam logic [vdi_pkg::IdxW-1:0] CellIdx = Pos[vdi_pkg::IdxW-1:0];

    vdi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (CellIdx),
      .item_i     (chain[i]),
      .item_o     (chain[i+1])
    );
  end

  assign last = chain[MAX_DISTINCT];

  assign idx_o.valid        = last.valid;
  assign idx_o.vertex_index = last.done ? last.idx : '0;
  assign idx_o.is_new       = last.done & last.is_new;
  assign idx_o.dropped      = ~last.done;

endmodule

`default_nettype wire

>>> rtl/vdi_cell.sv
// One table cell: holds one distinct vertex and matches or stores the passing transaction.
`default_nettype none

module vdi_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic [vdi_pkg::IdxW-1:0] cell_idx_i,
  input  wire vdi_pkg::vdi_item_t       item_i,
  output      vdi_pkg::vdi_item_t       item_o
);

  logic                     used_q;
  logic                     used_d;
  logic [vdi_pkg::KeyW-1:0] key_q;
  logic                     out_valid_q;
  vdi_pkg::vdi_item_t       out_q;
  vdi_pkg::vdi_item_t       item_d;
  logic                     eff_used;
  logic                     hit;
  logic                     take;

  // A mesh start clears each cell as its transaction passes, before the match.
  assign eff_used = used_q & ~(item_i.valid & item_i.clr);
  assign hit      = item_i.valid & ~item_i.done & eff_used & (key_q == item_i.key);
  assign take     = item_i.valid & ~item_i.done & ~eff_used;
  assign used_d   = take | eff_used;

  always_comb begin
    item_d = item_i;
    if (hit) begin
      item_d.done   = 1'b1;
      item_d.idx    = cell_idx_i;
      item_d.is_new = 1'b0;
    end else if (take) begin
      item_d.done   = 1'b1;
      item_d.idx    = cell_idx_i;
      item_d.is_new = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      used_q      <= used_d;
      out_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= item_d;
      if (take) begin
        key_q <= item_i.key;
      end
    end
  end

  always_comb begin
    item_o       = out_q;
    item_o.valid = out_valid_q;
  end

endmodule

`default_nettype wire

>>> rtl/vdi_checker.sv
// Port-level assertions for the vertex deduplicator and their bind to the top level.
`default_nettype none

module vdi_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [vdi_pkg::IdxW-1:0] vertex_index_i,
  input wire logic                     is_new_i,
  input wire logic                     dropped_i
);

  // The input side stalls exactly when a result is held back.
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_new_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(is_new_i && dropped_i))
    else $error("result is both new and dropped");

  a_dropped_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && dropped_i) |-> (vertex_index_i == '0))
    else $error("dropped result carries a nonzero index");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(vertex_index_i) && $stable(is_new_i) && $stable(dropped_i)))
    else $error("stalled result changed");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (vtx_i.ready),
  .out_valid_i    (idx_o.valid),
  .out_ready_i    (idx_o.ready),
  .vertex_index_i (idx_o.vertex_index),
  .is_new_i       (idx_o.is_new),
  .dropped_i      (idx_o.dropped)
);

`default_nettype wire

>>> dv/tb_vertex_dedup_indexer.sv
// Testbench for the vertex deduplicator: random-stall vertex streams checked against a predictor.
`timescale 1ns / 1ps

module tb_vertex_dedup_indexer;

  localparam int unsigned MaxDist = vdi_pkg::MaxDistinctDefault;
  localparam int unsigned WordW = vdi_pkg::WordW;
  localparam int unsigned KeyWords = vdi_pkg::KeyWords;
  localparam int unsigned KeyW = vdi_pkg::KeyW;
  localparam int unsigned IdxW = vdi_pkg::IdxW;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandomItems = 300;

  typedef logic [KeyW-1:0] vertex_key_t;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
    logic            is_new;
    logic            dropped;
  } index_result_t;

  logic clk_i;
  logic rst_ni;

  vdi_in_if  vtx ();
  vdi_out_if idx ();

  vertex_dedup_indexer #(
    .MAX_DISTINCT(MaxDist)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .idx_o (idx)
  );

  vertex_key_t   mesh_vertices[$];
  index_result_t pending_indices[$];
  int unsigned   error_count;
  int unsigned   calm_pct;
  int unsigned   idle_cycles;

  always #10 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    if ($urandom_range(0, 99) < calm_pct) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [WordW-1:0] draw_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h8000_0000;
      2: return '1;
      3: return 32'h7FC0_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_key_t draw_vertex();
    vertex_key_t key;
    for (int k = 0; k < KeyWords; k++) key[WordW*k +: WordW] = draw_word();
    return key;
  endfunction

  // Indices follow order of first appearance, which is the order in which the cells fill.
  function automatic index_result_t lookup_vertex(input logic mesh_start,
                                                  input vertex_key_t key);
    index_result_t res;
    res = '0;
    if (mesh_start) mesh_vertices.delete();
    for (int i = 0; i < mesh_vertices.size(); i++) begin
      if (mesh_vertices[i] == key) begin
        res.vertex_index = IdxW'(i);
        return res;
      end
    end
    if (mesh_vertices.size() < MaxDist) begin
      res.vertex_index = IdxW'(mesh_vertices.size());
      res.is_new = 1'b1;
      mesh_vertices.insert(mesh_vertices.size(), key);
    end else begin
      res.dropped = 1'b1;
    end
    return res;
  endfunction

  task automatic send_vertex(input logic mesh_start, input vertex_key_t key);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vtx.valid      <= 1'b1;
    vtx.mesh_start <= mesh_start;
    vtx.pos_x      <= key[WordW*0 +: WordW];
    vtx.pos_y      <= key[WordW*1 +: WordW];
    vtx.pos_z      <= key[WordW*2 +: WordW];
    vtx.tex_u      <= key[WordW*3 +: WordW];
    vtx.tex_v      <= key[WordW*4 +: WordW];
    vtx.norm_x     <= key[WordW*5 +: WordW];
    vtx.norm_y     <= key[WordW*6 +: WordW];
    vtx.norm_z     <= key[WordW*7 +: WordW];
    do @(posedge clk_i); while (!vtx.ready);
    pending_indices.insert(pending_indices.size(), lookup_vertex(mesh_start, key));
  endtask

  task automatic test_directed_cases();
    calm_pct = 50;
    send_vertex(1'b1, '0);
    send_vertex(1'b0, '1);
    send_vertex(1'b0, '0);
    send_vertex(1'b0, vertex_key_t'(32'h8000_0000));
    send_vertex(1'b0, '1);
    send_vertex(1'b0, {KeyWords{32'h7FC0_0000}});
    send_vertex(1'b0, {KeyWords{32'h7FC0_0001}});
    send_vertex(1'b0, {KeyWords{32'h7FC0_0000}});
    for (int k = 0; k < KeyWords; k++) send_vertex(1'b0, vertex_key_t'(1) << (WordW * k));
    send_vertex(1'b0, vertex_key_t'(32'h8000_0000) << (WordW * 7));
    send_vertex(1'b1, '1);
    send_vertex(1'b0, '0);
    send_vertex(1'b0, '1);
  endtask

  task automatic test_table_full();
    vertex_key_t key;
    calm_pct = 80;
    for (int n = 0; n < MaxDist; n++) begin
      key = draw_vertex();
      key[WordW-1:0] = WordW'(n);
      send_vertex(n == 0, key);
    end
    for (int n = 0; n < 24; n++) begin
      key = draw_vertex();
      case ($urandom_range(0, 2))
        0: key[WordW-1:0] = $urandom_range(MaxDist, 32'hFFFF_FFFF);
        1: key = mesh_vertices[$urandom_range(0, MaxDist - 1)];
        default: key = mesh_vertices[MaxDist - 1];
      endcase
      send_vertex(1'b0, key);
    end
    send_vertex(1'b1, mesh_vertices[MaxDist - 1]);
    send_vertex(1'b0, draw_vertex());
  endtask

  task automatic test_random_meshes();
    vertex_key_t pool[$];
    vertex_key_t key;
    int unsigned pool_size;
    int unsigned mesh_len;
    int unsigned roll;
    int unsigned sent;
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 3))
        0: calm_pct = 100;
        1: calm_pct = 0;
        default: calm_pct = 60;
      endcase
      pool.delete();
      pool_size = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 40);
      repeat (pool_size) pool.insert(pool.size(), draw_vertex());
      mesh_len = $urandom_range(1, 3 * pool_size);
      send_vertex(1'b1, pool[$urandom_range(0, pool_size - 1)]);
      sent++;
      for (int n = 1; n < mesh_len && sent < RandomItems; n++) begin
        roll = $urandom_range(0, 99);
        key = pool[$urandom_range(0, pool_size - 1)];
        if (roll >= 80 && roll < 90) begin
          key[$urandom_range(0, KeyW - 1)] ^= 1'b1;
        end else if (roll >= 90 && roll < 97) begin
          key = draw_vertex();
        end
        send_vertex(roll >= 97, key);
        sent++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    error_count = 0;
    calm_pct = 50;
    vtx.valid = 1'b0;
    vtx.mesh_start = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.tex_u = '0;
    vtx.tex_v = '0;
    vtx.norm_x = '0;
    vtx.norm_y = '0;
    vtx.norm_z = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_table_full();
    test_random_meshes();
    @(negedge clk_i);
    vtx.valid <= 1'b0;
    wait (pending_indices.size() == 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    index_result_t want;
    index_result_t got;
    idx.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait();
      @(negedge clk_i);
      if (stall != 0) begin
        idx.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      idx.ready <= 1'b1;
      do @(posedge clk_i); while (!idx.valid);
      got = '{vertex_index: idx.vertex_index, is_new: idx.is_new, dropped: idx.dropped};
      if (pending_indices.size() == 0) begin
        $display("%0t: unexpected result: expected none, got index %0d new %0b dropped %0b",
                 $time, got.vertex_index, got.is_new, got.dropped);
        error_count++;
      end else begin
        want = pending_indices.pop_front();
        if (got !== want) begin
          $display("%0t: expected index %0d new %0b dropped %0b, got index %0d new %0b dropped %0b",
                   $time, want.vertex_index, want.is_new, want.dropped,
                   got.vertex_index, got.is_new, got.dropped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (idx.valid && idx.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

>>> vertex_dedup_indexer.f
rtl/vdi_pkg.sv
rtl/vdi_in_if.sv
rtl/vdi_out_if.sv
rtl/vdi_cell.sv
rtl/vertex_dedup_indexer.sv
rtl/vdi_checker.sv
dv/tb_vertex_dedup_indexer.sv
